>>> design/rfws_pkg.sv
// Package: shared constants, types and helpers for the face wave speed unit.
`timescale 1ns / 1ps
package rfws_pkg;

  localparam int NUM_LANES = 4;
  localparam int WIDE_W    = 52;
  localparam int DIV_W     = WIDE_W + 16;
  localparam int DIV_STEPS = DIV_W;

  localparam logic [3:0] CMD_NORMAL       = 4'd0;
  localparam logic [3:0] CMD_TAN1         = 4'd1;
  localparam logic [3:0] CMD_TAN2         = 4'd2;
  localparam logic [3:0] CMD_LEFT_VEL     = 4'd3;
  localparam logic [3:0] CMD_LEFT_RHOC    = 4'd4;
  localparam logic [3:0] CMD_LEFT_DIAG    = 4'd5;
  localparam logic [3:0] CMD_LEFT_OFFDIAG = 4'd6;
  localparam logic [3:0] CMD_RIGHT_VEL    = 4'd7;
  localparam logic [3:0] CMD_RIGHT_RHOC   = 4'd8;
  localparam logic [3:0] CMD_RIGHT_DIAG   = 4'd9;
  localparam logic [3:0] CMD_RIGHT_OFFDIAG = 4'd10;

  typedef logic [2:0][31:0] vec3_t;

  function automatic vec3_t mk3(input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z);
    vec3_t v;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    return v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [WIDE_W-1:0] x);
    if (x > $signed(WIDE_W'(32'h7fffffff))) begin
      return 32'h7fffffff;
    end else if (x < -$signed(WIDE_W'(33'h80000000))) begin
      return 32'h80000000;
    end else begin
      return x[31:0];
    end
  endfunction

endpackage

>>> design/rfws_dot_lane.sv
// Dot-product lane: three Q16.16 products, registered, then a registered sum.
`timescale 1ns / 1ps
module rfws_dot_lane (
  input  logic                clk_i,
  input  logic                en_i,
  input  rfws_pkg::vec3_t     a_i,
  input  rfws_pkg::vec3_t     b_i,
  output logic signed [49:0]  sum_o,
  output logic [31:0]         sat_o
);
  import rfws_pkg::*;

  logic signed [63:0] full   [3];
  logic signed [47:0] prod_q [3];
  logic signed [49:0] sum_d, sum_q;

  for (genvar k = 0; k < 3; k++) begin : g_mul
    assign full[k] = $signed(a_i[k]) * $signed(b_i[k]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= full[k][63:16];
      end
    end
    sum_q <= sum_d;
  end

  assign sum_d = prod_q[0] + prod_q[1] + prod_q[2];
  assign sum_o = sum_q;
  assign sat_o = sat32(WIDE_W'(sum_q));

endmodule

>>> design/rfws_divider.sv
// Restoring divider, one quotient bit per cycle, Q16.16 saturated result.
`timescale 1ns / 1ps
module rfws_divider (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [rfws_pkg::WIDE_W-1:0] num_i,
  input  logic signed [rfws_pkg::WIDE_W-1:0] den_i,
  output logic                               done_o,
  output logic [31:0]                        quot_o
);
  import rfws_pkg::*;

  logic                busy_q, done_q, neg_q;
  logic [6:0]          cnt_q;
  logic [DIV_W-1:0]    dq_q;
  logic [WIDE_W-1:0]   rem_q, ad_q, rem_sh, rem_d, an, ad;
  logic                ge;

  assign an     = num_i[WIDE_W-1] ? WIDE_W'(-num_i) : WIDE_W'(num_i);
  assign ad     = den_i[WIDE_W-1] ? WIDE_W'(-den_i) : WIDE_W'(den_i);
  assign rem_sh = {rem_q[WIDE_W-2:0], dq_q[DIV_W-1]};
  assign ge     = rem_sh >= ad_q;
  assign rem_d  = ge ? rem_sh - ad_q : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= {an, 16'b0};
      rem_q <= '0;
      ad_q  <= ad;
      neg_q <= num_i[WIDE_W-1] ^ den_i[WIDE_W-1];
    end else if (busy_q) begin
      dq_q  <= {dq_q[DIV_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  always_comb begin
    if (neg_q) begin
      quot_o = (dq_q >= DIV_W'(33'h80000000)) ? 32'h80000000 : -dq_q[31:0];
    end else begin
      quot_o = (dq_q > DIV_W'(32'h7fffffff)) ? 32'h7fffffff : dq_q[31:0];
    end
  end

  assign done_o = done_q;

endmodule

>>> design/riemann_face_wave_speeds_unit.sv
// Top level: face state store, four dot-product lanes, merge and divider.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | cmd, comp_a, comp_b, comp_c
//  out     | output    | out_valid/out_ready| speeds, rotated velocities, stresses, invalid
//
// Group loads (cmd 0..9) store one group each; unused codes are dropped.
// The closing group (cmd 10) runs 7 lane steps and then a bit-serial divide; the result
// register loads once the divide is done and the output is free or being read.
// Input stays stalled while a face is computed; a pending result does not block loads.
// Reset clears the stored groups to zero and empties the result register.
`timescale 1ns / 1ps
module riemann_face_wave_speeds_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         cmd_i,
  input  logic signed [31:0] comp_a_i,
  input  logic signed [31:0] comp_b_i,
  input  logic signed [31:0] comp_c_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] contact_speed_o,
  output logic signed [31:0] left_speed_o,
  output logic signed [31:0] right_speed_o,
  output logic signed [31:0] left_normal_vel_o,
  output logic signed [31:0] left_tan1_vel_o,
  output logic signed [31:0] left_tan2_vel_o,
  output logic signed [31:0] left_normal_stress_o,
  output logic signed [31:0] right_normal_vel_o,
  output logic signed [31:0] right_tan1_vel_o,
  output logic signed [31:0] right_tan2_vel_o,
  output logic signed [31:0] right_normal_stress_o,
  output logic               invalid_o
);
  import rfws_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIV, ST_OUT} state_e;
  localparam logic [2:0] LAST_STEP = 3'd6;
  localparam logic [1:0] LAST_SUB  = 2'd2;

  state_e       state_q;
  logic [2:0]   step_q;
  logic [1:0]   sub_q;
  logic         in_acc, capture, div_start, div_done, res_load;
  logic [31:0]  quot;

  vec3_t        frame_q [3];
  vec3_t        vel_q   [2];
  vec3_t        diag_q  [2];
  vec3_t        off_q   [2];
  logic [31:0]  rho_q   [2];
  logic [31:0]  snd_q   [2];

  logic signed [31:0] ul_q, ur_q, lt1_q, lt2_q, rt1_q, rt2_q, sl_q, sr_q;
  logic signed [31:0] lo_q, hi_q, ml_q, mr_q;
  vec3_t              tl_q, tr_q;
  logic signed [49:0] p_q [4];
  logic               den_zero_q;

  vec3_t              lane_a [NUM_LANES];
  vec3_t              lane_b [NUM_LANES];
  logic signed [49:0] lane_sum [NUM_LANES];
  logic [31:0]        lane_sat [NUM_LANES];

  vec3_t              row_l [3];
  vec3_t              row_r [3];
  logic signed [WIDE_W-1:0] lo_w, hi_w, num_w, den_w;

  logic               out_valid_q;
  logic signed [31:0] res_q [11];
  logic               invalid_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign capture    = (state_q == ST_RUN) && (sub_q == LAST_SUB);
  assign div_start  = capture && (step_q == LAST_STEP);
  assign res_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) frame_q[i] <= '0;
      for (int i = 0; i < 2; i++) begin
        vel_q[i]  <= '0;
        diag_q[i] <= '0;
        off_q[i]  <= '0;
        rho_q[i]  <= '0;
        snd_q[i]  <= '0;
      end
    end else if (in_acc) begin
      case (cmd_i)
        CMD_NORMAL:        frame_q[0] <= mk3(comp_a_i, comp_b_i, comp_c_i);
        CMD_TAN1:          frame_q[1] <= mk3(comp_a_i, comp_b_i, comp_c_i);
        CMD_TAN2:          frame_q[2] <= mk3(comp_a_i, comp_b_i, comp_c_i);
        CMD_LEFT_VEL:      vel_q[0]   <= mk3(comp_a_i, comp_b_i, comp_c_i);
        CMD_LEFT_RHOC: begin
          rho_q[0] <= comp_a_i;
          snd_q[0] <= comp_b_i;
        end
        CMD_LEFT_DIAG:     diag_q[0]  <= mk3(comp_a_i, comp_b_i, comp_c_i);
        CMD_LEFT_OFFDIAG:  off_q[0]   <= mk3(comp_a_i, comp_b_i, comp_c_i);
        CMD_RIGHT_VEL:     vel_q[1]   <= mk3(comp_a_i, comp_b_i, comp_c_i);
        CMD_RIGHT_RHOC: begin
          rho_q[1] <= comp_a_i;
          snd_q[1] <= comp_b_i;
        end
        CMD_RIGHT_DIAG:    diag_q[1]  <= mk3(comp_a_i, comp_b_i, comp_c_i);
        CMD_RIGHT_OFFDIAG: off_q[1]   <= mk3(comp_a_i, comp_b_i, comp_c_i);
        default: ;
      endcase
    end
  end

  // stress rows: (xx,xy,xz) (xy,yy,yz) (xz,yz,zz)
  assign row_l[0] = mk3(diag_q[0][0], off_q[0][0], off_q[0][1]);
  assign row_l[1] = mk3(off_q[0][0], diag_q[0][1], off_q[0][2]);
  assign row_l[2] = mk3(off_q[0][1], off_q[0][2], diag_q[0][2]);
  assign row_r[0] = mk3(diag_q[1][0], off_q[1][0], off_q[1][1]);
  assign row_r[1] = mk3(off_q[1][0], diag_q[1][1], off_q[1][2]);
  assign row_r[2] = mk3(off_q[1][1], off_q[1][2], diag_q[1][2]);

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      lane_a[l] = '0;
      lane_b[l] = '0;
    end
    case (step_q)
      3'd0: begin
        lane_a[0] = vel_q[0]; lane_b[0] = frame_q[0];
        lane_a[1] = vel_q[1]; lane_b[1] = frame_q[0];
        lane_a[2] = vel_q[0]; lane_b[2] = frame_q[1];
        lane_a[3] = vel_q[0]; lane_b[3] = frame_q[2];
      end
      3'd1: begin
        lane_a[0] = vel_q[1]; lane_b[0] = frame_q[1];
        lane_a[1] = vel_q[1]; lane_b[1] = frame_q[2];
        lane_a[2] = row_l[0]; lane_b[2] = frame_q[0];
        lane_a[3] = row_l[1]; lane_b[3] = frame_q[0];
      end
      3'd2: begin
        lane_a[0] = row_l[2]; lane_b[0] = frame_q[0];
        lane_a[1] = row_r[0]; lane_b[1] = frame_q[0];
        lane_a[2] = row_r[1]; lane_b[2] = frame_q[0];
        lane_a[3] = row_r[2]; lane_b[3] = frame_q[0];
      end
      3'd3: begin
        lane_a[0] = frame_q[0]; lane_b[0] = tl_q;
        lane_a[1] = frame_q[0]; lane_b[1] = tr_q;
      end
      3'd4: begin
        lane_a[0] = mk3(rho_q[0], '0, '0); lane_b[0] = mk3(ul_q, '0, '0);
        lane_a[1] = mk3(rho_q[1], '0, '0); lane_b[1] = mk3(ur_q, '0, '0);
      end
      3'd5: begin
        lane_a[0] = mk3(ml_q, '0, '0); lane_b[0] = mk3(ul_q, '0, '0);
        lane_a[1] = mk3(mr_q, '0, '0); lane_b[1] = mk3(ur_q, '0, '0);
        lane_a[2] = mk3(lo_q, '0, '0); lane_b[2] = mk3(ml_q, '0, '0);
        lane_a[3] = mk3(hi_q, '0, '0); lane_b[3] = mk3(mr_q, '0, '0);
      end
      3'd6: begin
        lane_a[0] = mk3(lo_q, '0, '0); lane_b[0] = mk3(rho_q[0], '0, '0);
        lane_a[1] = mk3(hi_q, '0, '0); lane_b[1] = mk3(rho_q[1], '0, '0);
      end
      default: ;
    endcase
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    rfws_dot_lane u_lane (
      .clk_i (clk_i),
      .en_i  ((state_q == ST_RUN) && (sub_q == 2'd0)),
      .a_i   (lane_a[l]),
      .b_i   (lane_b[l]),
      .sum_o (lane_sum[l]),
      .sat_o (lane_sat[l])
    );
  end

  // Davis bounds from saturated normal velocities
  always_comb begin
    logic signed [WIDE_W-1:0] dl, dr, al, ar;
    dl = WIDE_W'(ul_q) - WIDE_W'($signed(snd_q[0]));
    dr = WIDE_W'(ur_q) - WIDE_W'($signed(snd_q[1]));
    al = WIDE_W'(ul_q) + WIDE_W'($signed(snd_q[0]));
    ar = WIDE_W'(ur_q) + WIDE_W'($signed(snd_q[1]));
    lo_w = (dl < dr) ? dl : dr;
    hi_w = (al > ar) ? al : ar;
  end

  // merge: contact numerator and denominator
  assign num_w = WIDE_W'(p_q[0]) + WIDE_W'(sl_q) - WIDE_W'(p_q[1]) - WIDE_W'(sr_q)
               - WIDE_W'(p_q[2]) + WIDE_W'(p_q[3]);
  assign den_w = WIDE_W'(ml_q) - WIDE_W'(mr_q) - WIDE_W'(lane_sum[0])
               + WIDE_W'(lane_sum[1]);

  always_ff @(posedge clk_i) begin
    if (capture) begin
      case (step_q)
        3'd0: begin
          ul_q <= lane_sat[0]; ur_q <= lane_sat[1];
          lt1_q <= lane_sat[2]; lt2_q <= lane_sat[3];
        end
        3'd1: begin
          rt1_q <= lane_sat[0]; rt2_q <= lane_sat[1];
          tl_q[0] <= lane_sat[2]; tl_q[1] <= lane_sat[3];
        end
        3'd2: begin
          tl_q[2] <= lane_sat[0];
          tr_q <= mk3(lane_sat[1], lane_sat[2], lane_sat[3]);
        end
        3'd3: begin
          sl_q <= lane_sat[0]; sr_q <= lane_sat[1];
          lo_q <= sat32(lo_w); hi_q <= sat32(hi_w);
        end
        3'd4: begin
          ml_q <= lane_sat[0]; mr_q <= lane_sat[1];
        end
        3'd5: begin
          for (int l = 0; l < NUM_LANES; l++) p_q[l] <= lane_sum[l];
        end
        3'd6: den_zero_q <= (den_w == '0);
        default: ;
      endcase
    end
  end

  rfws_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_w),
    .den_i   (den_w),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      sub_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (res_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (cmd_i == CMD_RIGHT_OFFDIAG)) begin
            state_q <= ST_RUN;
            step_q  <= '0;
            sub_q   <= '0;
          end
        end
        ST_RUN: begin
          if (sub_q == LAST_SUB) begin
            sub_q <= '0;
            if (step_q == LAST_STEP) begin
              state_q <= ST_DIV;
            end else begin
              step_q <= step_q + 3'd1;
            end
          end else begin
            sub_q <= sub_q + 2'd1;
          end
        end
        ST_DIV: begin
          if (div_done) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (res_load) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q[0]  <= den_zero_q ? 32'sd0 : $signed(quot);
      res_q[1]  <= lo_q;
      res_q[2]  <= hi_q;
      res_q[3]  <= ul_q;
      res_q[4]  <= lt1_q;
      res_q[5]  <= lt2_q;
      res_q[6]  <= sl_q;
      res_q[7]  <= ur_q;
      res_q[8]  <= rt1_q;
      res_q[9]  <= rt2_q;
      res_q[10] <= sr_q;
      invalid_q <= den_zero_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign contact_speed_o       = res_q[0];
  assign left_speed_o          = res_q[1];
  assign right_speed_o         = res_q[2];
  assign left_normal_vel_o     = res_q[3];
  assign left_tan1_vel_o       = res_q[4];
  assign left_tan2_vel_o       = res_q[5];
  assign left_normal_stress_o  = res_q[6];
  assign right_normal_vel_o    = res_q[7];
  assign right_tan1_vel_o      = res_q[8];
  assign right_tan2_vel_o      = res_q[9];
  assign right_normal_stress_o = res_q[10];
  assign invalid_o             = invalid_q;

endmodule

>>> design/rfws_checker.sv
// Port-level checker for the face wave speed unit, bound to the top level.
`timescale 1ns / 1ps
module rfws_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [3:0]         cmd_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] contact_speed_o,
  input logic               invalid_o
);
  import rfws_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transaction");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(contact_speed_o))
    else $error("result changed while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |-> contact_speed_o == 32'sd0)
    else $error("invalid result with nonzero contact speed");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == CMD_RIGHT_OFFDIAG) |=> !in_ready_o)
    else $error("input taken during face computation");

  a_rise_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without computation");

endmodule

bind riemann_face_wave_speeds_unit rfws_checker u_rfws_checker (.*);
